FILE: src/ckpc_pkg.sv
package ckpc_pkg;

  localparam int COORD_BITS = 12;
  localparam int COLOR_BITS = 8;
  localparam int KEY_BITS   = 3 * COLOR_BITS;
  // The count saturates at 2^24, so it needs one bit more than the key.
  localparam int COUNT_BITS = 25;
  localparam int REM_BITS   = COUNT_BITS - 1;
  localparam int SUM_BITS   = COORD_BITS + REM_BITS;
  localparam int STEP_BITS  = $clog2(COORD_BITS);

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_blue;
    logic [COLOR_BITS-1:0] pixel_green;
    logic [COLOR_BITS-1:0] pixel_red;
    logic                  frame_end;
  } pixel_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] mean_x;
    logic [COORD_BITS-1:0] mean_y;
    logic [COUNT_BITS-1:0] match_count;
    logic                  no_match;
  } centroid_t;

  typedef struct packed {
    logic [SUM_BITS-1:0]   sum_x;
    logic [SUM_BITS-1:0]   sum_y;
    logic [COUNT_BITS-1:0] count;
  } frame_acc_t;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_DIV  = 3'b010,
    BK_OUT  = 3'b100
  } back_state_t;

endpackage

FILE: src/color_keyed_pixel_centroid.sv
// Color-keyed centroid: pixels enter at one per clock; each pixel whose RGB equals
// the key color adds its x and y to running sums, and the last pixel of a frame
// (itself counted) hands the sums to a small queue and produces one beat with the
// truncated mean x and y and the match count, or no_match with zero coordinates
// when nothing matched. Matches beyond 2^24 in one frame are ignored. With the
// divider idle and the output not stalled, the divider loads the frame from the
// queue, works out one quotient bit per cycle in a restoring divider with shared
// control that works both axes at once, and then registers the output beat; a
// frame with no match skips the division. The input stalls only when QUEUE_DEPTH
// frames wait for that divider, so later frames keep streaming in while it works.
module color_keyed_pixel_centroid #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ckpc_pkg::KEY_BITS-1:0] cfg_key_color,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ckpc_pkg::pixel_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ckpc_pkg::centroid_t           out_data
);
  import ckpc_pkg::*;

  logic       q_full;
  logic       q_push;
  frame_acc_t q_push_data;
  logic       q_valid;
  logic       q_pop;
  frame_acc_t q_data;

  ckpc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_key_color (cfg_key_color),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_push_data   (q_push_data)
  );

  ckpc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (q_data)
  );

  ckpc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.no_match |->
      out_data.mean_x == '0 && out_data.mean_y == '0 && out_data.match_count == '0)
    else $error("empty frame result carries nonzero fields");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.no_match |-> out_data.match_count != '0)
    else $error("non-empty result with zero count");

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.match_count[COUNT_BITS-1] &&
                    (out_data.match_count[COUNT_BITS-2:0] != '0)))
    else $error("match count above saturation limit");

endmodule

FILE: src/ckpc_front.sv
module ckpc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ckpc_pkg::KEY_BITS-1:0] cfg_key_color,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ckpc_pkg::pixel_t              in_data,
  input  logic                          q_full,
  output logic                          q_push,
  output ckpc_pkg::frame_acc_t          q_push_data
);
  import ckpc_pkg::*;

  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [SUM_BITS-1:0]   sum_x_r, sum_x_nxt, sum_x_add;
  logic [SUM_BITS-1:0]   sum_y_r, sum_y_nxt, sum_y_add;
  logic [COUNT_BITS-1:0] count_r, count_nxt, count_add;
  logic                  accept;
  logic                  match;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;

  // Once the count reaches 2^24 (top bit set) further matches are dropped.
  assign match = ({in_data.pixel_red, in_data.pixel_green, in_data.pixel_blue} == key_r)
                 && !count_r[COUNT_BITS-1];

  assign sum_x_add = sum_x_r + (match ? SUM_BITS'(in_data.pixel_x) : '0);
  assign sum_y_add = sum_y_r + (match ? SUM_BITS'(in_data.pixel_y) : '0);
  assign count_add = count_r + COUNT_BITS'(match);

  assign q_push            = accept && in_data.frame_end;
  assign q_push_data.sum_x = sum_x_add;
  assign q_push_data.sum_y = sum_y_add;
  assign q_push_data.count = count_add;

  always_comb begin
    key_nxt   = key_r;
    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    count_nxt = count_r;
    if (cfg_valid && cfg_ready) begin
      key_nxt = cfg_key_color;
    end
    if (accept) begin
      if (in_data.frame_end) begin
        sum_x_nxt = '0;
        sum_y_nxt = '0;
        count_nxt = '0;
      end else begin
        sum_x_nxt = sum_x_add;
        sum_y_nxt = sum_y_add;
        count_nxt = count_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      count_r <= '0;
    end else begin
      key_r   <= key_nxt;
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

FILE: src/ckpc_fifo.sv
module ckpc_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ckpc_pkg::frame_acc_t push_data,
  output logic                 full,
  output logic                 pop_valid,
  input  logic                 pop,
  output ckpc_pkg::frame_acc_t pop_data
);
  import ckpc_pkg::*;

  localparam int PTR_BITS  = $clog2(DEPTH);
  localparam int FILL_BITS = $clog2(DEPTH + 1);

  frame_acc_t            mem_r [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FILL_BITS-1:0]  fill_r, fill_nxt;
  logic                  do_push;
  logic                  do_pop;

  assign full      = (fill_r == FILL_BITS'(DEPTH));
  assign pop_valid = (fill_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

FILE: src/ckpc_div.sv
module ckpc_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  ckpc_pkg::frame_acc_t q_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ckpc_pkg::centroid_t  out_data
);
  import ckpc_pkg::*;

  back_state_t           state_r, state_nxt;
  logic [STEP_BITS-1:0]  step_r, step_nxt;
  logic [REM_BITS-1:0]   rem_x_r, rem_x_nxt, rem_y_r, rem_y_nxt;
  // Low sum bits shift out at the top while quotient bits shift in below.
  logic [COORD_BITS-1:0] quo_x_r, quo_x_nxt, quo_y_r, quo_y_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  empty_r, empty_nxt;
  logic                  out_valid_r, out_valid_nxt;
  centroid_t             out_data_r, out_data_nxt;
  logic [COUNT_BITS-1:0] trial_x, trial_y;
  logic                  ge_x, ge_y;
  logic                  out_free;

  assign trial_x  = {rem_x_r, quo_x_r[COORD_BITS-1]};
  assign trial_y  = {rem_y_r, quo_y_r[COORD_BITS-1]};
  assign ge_x     = (trial_x >= count_r);
  assign ge_y     = (trial_y >= count_r);
  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == BK_IDLE) && q_valid;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    rem_x_nxt     = rem_x_r;
    rem_y_nxt     = rem_y_r;
    quo_x_nxt     = quo_x_r;
    quo_y_nxt     = quo_y_r;
    count_nxt     = count_r;
    empty_nxt     = empty_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          // The quotient fits the coordinate width, so the upper sum bits
          // are already below the count and seed the remainder.
          rem_x_nxt = q_data.sum_x[SUM_BITS-1 -: REM_BITS];
          rem_y_nxt = q_data.sum_y[SUM_BITS-1 -: REM_BITS];
          quo_x_nxt = q_data.sum_x[COORD_BITS-1:0];
          quo_y_nxt = q_data.sum_y[COORD_BITS-1:0];
          count_nxt = q_data.count;
          empty_nxt = (q_data.count == '0);
          step_nxt  = STEP_BITS'(COORD_BITS - 1);
          state_nxt = (q_data.count == '0) ? BK_OUT : BK_DIV;
        end
      end
      BK_DIV: begin
        rem_x_nxt = ge_x ? REM_BITS'(trial_x - count_r) : trial_x[REM_BITS-1:0];
        rem_y_nxt = ge_y ? REM_BITS'(trial_y - count_r) : trial_y[REM_BITS-1:0];
        quo_x_nxt = {quo_x_r[COORD_BITS-2:0], ge_x};
        quo_y_nxt = {quo_y_r[COORD_BITS-2:0], ge_y};
        step_nxt  = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = BK_OUT;
        end
      end
      BK_OUT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.mean_x      = empty_r ? '0 : quo_x_r;
          out_data_nxt.mean_y      = empty_r ? '0 : quo_y_r;
          out_data_nxt.match_count = count_r;
          out_data_nxt.no_match    = empty_r;
          state_nxt                = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rem_x_r    <= rem_x_nxt;
    rem_y_r    <= rem_y_nxt;
    quo_x_r    <= quo_x_nxt;
    quo_y_r    <= quo_y_nxt;
    count_r    <= count_nxt;
    empty_r    <= empty_nxt;
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
